@@ rtl/dlc_pkg.sv @@
// ----------------------------------------------------------------------------
// dlc_pkg - shared types and constants of the dimmer level controller
// Opcodes, register indexes, field widths and the compare unit result.
// ----------------------------------------------------------------------------
package dlc_pkg;

    localparam int LEVEL_W = 4;
    localparam int DUTY_W  = 8;
    localparam int REQ_W   = 8;
    localparam int COUNT_W = 5;
    localparam int TAB_W   = 64;

    typedef enum logic [2:0] {
        OP_SET_ON        = 3'd0,
        OP_SET_LEVEL     = 3'd1,
        OP_STEP_DOWN     = 3'd2,
        OP_STEP_UP       = 3'd3,
        OP_RESTORE_PWM   = 3'd4,
        OP_RESTORE_LEVEL = 3'd5,
        OP_RECONCILE     = 3'd6,
        OP_NOP           = 3'd7
    } opcode_t;

    typedef enum logic [1:0] {
        REG_LEVEL_COUNT = 2'd0,
        REG_TABLE_LO    = 2'd1,
        REG_TABLE_HI    = 2'd2,
        REG_UNUSED      = 2'd3
    } reg_index_t;

    // result of the shared table read and compare
    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              le;
        logic              eq;
    } cmp_result_t;

endpackage

@@ rtl/dlc_duty_cmp.sv @@
// ----------------------------------------------------------------------------
// dlc_duty_cmp - shared table read and duty compare unit
// Selects one duty byte of the level table and compares it against a duty.
// ----------------------------------------------------------------------------
module dlc_duty_cmp (
    input  logic [dlc_pkg::TAB_W-1:0]   table_lo,
    input  logic [dlc_pkg::TAB_W-1:0]   table_hi,
    input  logic [dlc_pkg::LEVEL_W-1:0] index,
    input  logic [dlc_pkg::DUTY_W-1:0]  ref_duty,
    output dlc_pkg::cmp_result_t        result
);
    import dlc_pkg::*;

    logic [TAB_W-1:0]  word;
    logic [DUTY_W-1:0] duty;

    assign word = index[LEVEL_W-1] ? table_hi : table_lo;
    assign duty = word[index[LEVEL_W-2:0]*DUTY_W +: DUTY_W];

    assign result.duty = duty;
    assign result.le   = (duty <= ref_duty);
    assign result.eq   = (duty == ref_duty);

endmodule

@@ rtl/dimmer_level_controller.sv @@
// ----------------------------------------------------------------------------
// dimmer_level_controller - dimmer on flag, level and duty keeper
// Runs one opcode per item against a configured table of level duties.
// ----------------------------------------------------------------------------
// Sequence: set_on, opcode 7, range errors and a step down while off go
//   straight to the done state; level and step opcodes fetch the new duty
//   first; a reconcile or restore_with_pwm triple that already matches the
//   table is kept after the check, else the shared comparator walks the
//   entries, one per cycle, and the chosen level's duty is then fetched.
//   The done state holds while the result register is full and not taken.
// Throughput: one item at a time; s_tready is high only while idle.
// Reset: synchronous, active low; on flag off, level 15, duty 0, count 16,
//   table zero.
module dimmer_level_controller #(
    parameter int MAX_LEVELS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    // command items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [0] on_value, [8:1] level_value,
                                   // [16:9] pwm_value, [23:17] zero
    input  logic [2:0]  s_tuser,   // [2:0] opcode
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [0] light_is_on, [4:1] level_now,
                                   // [12:5] duty_now, [13] status, [15:14] zero
);
    import dlc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_WALK,
        ST_FETCH,
        ST_DONE
    } state_t;

    localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_LEVELS);

    // configuration registers
    logic [COUNT_W-1:0] count_reg;
    logic [TAB_W-1:0]   table_lo_reg;
    logic [TAB_W-1:0]   table_hi_reg;

    // dimmer state
    logic               on_reg;
    logic [LEVEL_W-1:0] level_reg;
    logic [DUTY_W-1:0]  duty_reg;
    logic               status_reg;

    // sequencer and reconcile candidate
    state_t             state_reg;
    logic               cand_on_reg;
    logic [REQ_W-1:0]   cand_lvl_reg;
    logic [DUTY_W-1:0]  cand_pwm_reg;
    logic [LEVEL_W-1:0] idx_reg;

    // output register
    logic               m_valid_reg;
    logic [15:0]        m_data_reg;

    // command fields
    opcode_t            opcode;
    logic               on_value;
    logic [REQ_W-1:0]   level_value;
    logic [DUTY_W-1:0]  pwm_value;

    logic [COUNT_W-1:0] eff_count;
    logic [LEVEL_W-1:0] top_level;
    logic [COUNT_W-1:0] level_inc;
    logic [LEVEL_W-1:0] cmp_index;
    cmp_result_t        cmp;
    logic               in_accept;
    logic               out_free;

    assign opcode      = opcode_t'(s_tuser);
    assign on_value    = s_tdata[0];
    assign level_value = s_tdata[8:1];
    assign pwm_value   = s_tdata[16:9];

    // Clamp the count: zero acts as one, anything above the table acts as full.
    always_comb begin
        priority if (count_reg == '0) begin
            eff_count = COUNT_W'(1);
        end else if (count_reg > MAX_COUNT) begin
            eff_count = MAX_COUNT;
        end else begin
            eff_count = count_reg;
        end
    end

    assign top_level = LEVEL_W'(eff_count - COUNT_W'(1));
    assign level_inc = {1'b0, level_reg} + COUNT_W'(1);

    // Steer the one shared compare unit: candidate level during the check,
    // walk index during the search, chosen level when fetching its duty.
    always_comb begin
        unique case (state_reg)
            ST_CHECK: cmp_index = cand_lvl_reg[LEVEL_W-1:0];
            ST_WALK:  cmp_index = idx_reg;
            default:  cmp_index = level_reg;
        endcase
    end

    dlc_duty_cmp u_cmp (
        .table_lo (table_lo_reg),
        .table_hi (table_hi_reg),
        .index    (cmp_index),
        .ref_duty (cand_pwm_reg),
        .result   (cmp)
    );

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    // Configuration writes; index three is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= COUNT_W'(16);
            table_lo_reg <= '0;
            table_hi_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (reg_index_t'(cfg_index))
                REG_LEVEL_COUNT: count_reg    <= cfg_data[COUNT_W-1:0];
                REG_TABLE_LO:    table_lo_reg <= cfg_data;
                REG_TABLE_HI:    table_hi_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            on_reg      <= 1'b0;
            level_reg   <= LEVEL_W'(15);
            duty_reg    <= '0;
            status_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            // drop the result once the consumer takes it, unless a new one
            // is loaded in the same cycle
            if (m_valid_reg && m_tready && state_reg != ST_DONE) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (in_accept) begin
                        status_reg <= 1'b0;
                        state_reg  <= ST_DONE;
                        unique case (opcode)
                            OP_SET_ON: begin
                                on_reg <= on_value;
                            end
                            OP_SET_LEVEL: begin
                                if (level_value < REQ_W'(eff_count)) begin
                                    on_reg    <= 1'b1;
                                    level_reg <= level_value[LEVEL_W-1:0];
                                    state_reg <= ST_FETCH;
                                end else begin
                                    status_reg <= 1'b1;
                                end
                            end
                            OP_STEP_DOWN: begin
                                if (on_reg) begin
                                    // at the bottom, turn off and park at the top
                                    if (level_reg == '0) begin
                                        on_reg    <= 1'b0;
                                        level_reg <= top_level;
                                    end else begin
                                        level_reg <= level_reg - LEVEL_W'(1);
                                    end
                                    state_reg <= ST_FETCH;
                                end
                            end
                            OP_STEP_UP: begin
                                on_reg <= 1'b1;
                                if (level_inc > {1'b0, top_level}) begin
                                    level_reg <= top_level;
                                end else begin
                                    level_reg <= level_inc[LEVEL_W-1:0];
                                end
                                state_reg <= ST_FETCH;
                            end
                            OP_RESTORE_PWM: begin
                                cand_on_reg  <= on_value;
                                cand_lvl_reg <= level_value;
                                cand_pwm_reg <= pwm_value;
                                state_reg    <= ST_CHECK;
                            end
                            OP_RESTORE_LEVEL: begin
                                if (level_value > REQ_W'(top_level)) begin
                                    status_reg <= 1'b1;
                                end else begin
                                    on_reg    <= on_value;
                                    level_reg <= level_value[LEVEL_W-1:0];
                                    state_reg <= ST_FETCH;
                                end
                            end
                            OP_RECONCILE: begin
                                cand_on_reg  <= on_reg;
                                cand_lvl_reg <= REQ_W'(level_reg);
                                cand_pwm_reg <= duty_reg;
                                state_reg    <= ST_CHECK;
                            end
                            default: ;
                        endcase
                    end
                end

                ST_CHECK: begin
                    // keep a triple that already matches the table
                    if (cand_lvl_reg < REQ_W'(eff_count) && cmp.eq) begin
                        on_reg    <= cand_on_reg;
                        level_reg <= cand_lvl_reg[LEVEL_W-1:0];
                        duty_reg  <= cand_pwm_reg;
                        state_reg <= ST_DONE;
                    end else begin
                        idx_reg   <= '0;
                        state_reg <= ST_WALK;
                    end
                end

                ST_WALK: begin
                    // walk upward while the entry stays at or below the duty
                    if (cmp.le && idx_reg == top_level) begin
                        on_reg    <= cand_on_reg;
                        level_reg <= idx_reg;
                        state_reg <= ST_FETCH;
                    end else if (cmp.le) begin
                        idx_reg <= idx_reg + LEVEL_W'(1);
                    end else if (idx_reg == '0) begin
                        // even level zero is too bright: off at the top
                        on_reg    <= 1'b0;
                        level_reg <= top_level;
                        state_reg <= ST_FETCH;
                    end else begin
                        on_reg    <= cand_on_reg;
                        level_reg <= idx_reg - LEVEL_W'(1);
                        state_reg <= ST_FETCH;
                    end
                end

                ST_FETCH: begin
                    duty_reg  <= cmp.duty;
                    state_reg <= ST_DONE;
                end

                ST_DONE: begin
                    // hold until the output register is free
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {2'b00, status_reg, duty_reg, level_reg, on_reg};
                        state_reg   <= ST_IDLE;
                    end
                end

                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // an accepted item keeps the block busy in the next cycle
    a_busy_after_accept: assert property (
        @(posedge aclk) disable iff (!aresetn)
        in_accept |=> !s_tready
    ) else $error("block ready right after accepting an item");

    // the search never runs past the last valid level
    a_walk_in_range: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK) |-> (idx_reg <= top_level)
    ) else $error("table walk beyond the level count");

    // a finished item with a free output register shows up as a result
    a_done_delivers: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && out_free) |=> (m_tvalid && s_tready)
    ) else $error("finished item not delivered");

endmodule

@@ sim/dimmer_level_controller_tb.sv @@
// ----------------------------------------------------------------------------
// dimmer_level_controller_tb - self-checking bench for the dimmer controller
// Drives command items and table writes, predicts each result from a
// behavioral copy of the dimmer state and compares it field by field.
// ----------------------------------------------------------------------------
module dimmer_level_controller_tb;
    import dlc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_LEVELS    = 16;
    localparam int STALL_LIMIT   = 5000;  // cycles without any handshake
    localparam int SETTLE_CYCLES = 30;    // settle time after the drain
    localparam int RANDOM_ITEMS  = 68;    // per table setting

    // one result item as it sits in m_tdata[13:0], last field lowest
    typedef struct packed {
        logic       status;
        logic [7:0] duty;
        logic [3:0] level;
        logic       on;
    } lamp_report_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [63:0] cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;   // [0] on_value, [8:1] level_value,
                                   // [16:9] pwm_value, [23:17] zero
    logic [2:0]  s_tuser   = '0;   // [2:0] opcode
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;          // [0] light_is_on, [4:1] level_now,
                                   // [12:5] duty_now, [13] status

    // percentage of cycles in which the sender idles / the receiver stalls
    int unsigned src_idle_pct = 0;
    int unsigned snk_stall_pct = 0;

    // predicted dimmer state and its table settings
    logic        lamp_on;
    logic [3:0]  lamp_level;
    logic [7:0]  lamp_duty;
    logic [4:0]  count_reg;
    logic [63:0] duty_table_lo;
    logic [63:0] duty_table_hi;

    lamp_report_t pending_reports[$];
    lamp_report_t got_report;
    lamp_report_t want_report;
    int unsigned  mismatch_count = 0;
    int unsigned  quiet_cycles = 0;

    dimmer_level_controller #(
        .MAX_LEVELS(MAX_LEVELS)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // clamp the count register into 1..MAX_LEVELS
    function automatic int active_levels();
        int n;
        n = count_reg;
        if (n == 0) n = 1;
        if (n > MAX_LEVELS) n = MAX_LEVELS;
        return n;
    endfunction

    function automatic logic [7:0] table_duty(logic [3:0] idx);
        if (idx < 8) return duty_table_lo[idx[2:0]*8 +: 8];
        return duty_table_hi[idx[2:0]*8 +: 8];
    endfunction

    // snap an (on, level, duty) triple onto the table: keep it when it matches,
    // else take the highest level reached before an entry rises above the duty
    function automatic void snap_to_table(logic on_v, int lvl, logic [7:0] pwm);
        int  n;
        int  i;
        bit  walking;
        n = active_levels();
        if (lvl < n && table_duty(lvl[3:0]) == pwm) begin
            lamp_on    = on_v;
            lamp_level = lvl[3:0];
            lamp_duty  = pwm;
            return;
        end
        // nothing at or below the duty: turn off and park at the top
        lamp_on    = 1'b0;
        lamp_level = 4'(n - 1);
        walking    = 1'b1;
        for (i = 0; i < n && walking; i++) begin
            if (table_duty(4'(i)) <= pwm) begin
                lamp_on    = on_v;
                lamp_level = 4'(i);
            end else begin
                walking = 1'b0;
            end
        end
        lamp_duty = table_duty(lamp_level);
    endfunction

    // advance the predicted state by one command and return the result item
    function automatic lamp_report_t apply_command(opcode_t op, logic on_v,
                                                   logic [7:0] lvl_v,
                                                   logic [7:0] pwm_v);
        lamp_report_t rep;
        int           n;
        int           nxt;
        n          = active_levels();
        rep.status = 1'b0;
        case (op)
            OP_SET_ON: begin
                lamp_on = on_v;
            end
            OP_SET_LEVEL: begin
                if (lvl_v < n) begin
                    lamp_on    = 1'b1;
                    lamp_level = lvl_v[3:0];
                    lamp_duty  = table_duty(lvl_v[3:0]);
                end else begin
                    rep.status = 1'b1;
                end
            end
            OP_STEP_DOWN: begin
                // off: nothing; at level 0: off and park at the top level
                if (lamp_on) begin
                    if (lamp_level == 0) begin
                        lamp_on    = 1'b0;
                        lamp_level = 4'(n - 1);
                    end else begin
                        lamp_level = lamp_level - 4'd1;
                    end
                    lamp_duty = table_duty(lamp_level);
                end
            end
            OP_STEP_UP: begin
                nxt = lamp_level + 1;
                if (nxt > n - 1) nxt = n - 1;
                lamp_on    = 1'b1;
                lamp_level = 4'(nxt);
                lamp_duty  = table_duty(lamp_level);
            end
            OP_RESTORE_PWM: begin
                snap_to_table(on_v, lvl_v, pwm_v);
            end
            OP_RESTORE_LEVEL: begin
                if (lvl_v > n - 1) begin
                    rep.status = 1'b1;
                end else begin
                    lamp_on    = on_v;
                    lamp_level = lvl_v[3:0];
                    lamp_duty  = table_duty(lvl_v[3:0]);
                end
            end
            OP_RECONCILE: begin
                snap_to_table(lamp_on, lamp_level, lamp_duty);
            end
            default: ;  // unused opcode leaves everything alone
        endcase
        rep.on    = lamp_on;
        rep.level = lamp_level;
        rep.duty  = lamp_duty;
        return rep;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus primitives
    // ------------------------------------------------------------------

    // drive one command item; valid stays high afterwards so back-to-back
    // items need no second assignment in the same step
    task automatic send_item(opcode_t op, logic on_v, logic [7:0] lvl_v,
                             logic [7:0] pwm_v);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'd0, pwm_v, lvl_v, on_v};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_reports.push_back(apply_command(op, on_v, lvl_v, pwm_v));
    endtask

    // drop valid and hold until every predicted result has come back
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_LEVEL_COUNT: count_reg     = value[4:0];
            REG_TABLE_LO:    duty_table_lo = value;
            REG_TABLE_HI:    duty_table_hi = value;
            default: ;
        endcase
    endtask

    // reprogram the whole table once the block has gone idle
    task automatic load_table(logic [4:0] count, logic [63:0] lo, logic [63:0] hi);
        wait_idle();
        write_reg(REG_LEVEL_COUNT, {59'd0, count});
        write_reg(REG_TABLE_LO, lo);
        write_reg(REG_TABLE_HI, hi);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // reset table is all zero with sixteen levels
    task automatic test_after_reset();
        send_item(OP_RECONCILE, 1'b0, 8'd0, 8'd0);
        send_item(OP_STEP_DOWN, 1'b0, 8'd0, 8'd0);
        send_item(OP_STEP_UP, 1'b0, 8'd0, 8'd0);
        send_item(OP_SET_ON, 1'b0, 8'd0, 8'd0);
    endtask

    // five ascending levels: 10, 40, 80, 120, 200
    task automatic test_each_opcode();
        load_table(5'd5, 64'hFF_FF_FF_C8_78_50_28_0A, 64'h00_11_22_33_44_55_66_77);
        send_item(OP_SET_ON, 1'b1, 8'd0, 8'd0);
        send_item(OP_SET_LEVEL, 1'b0, 8'd0, 8'd0);
        send_item(OP_STEP_DOWN, 1'b0, 8'd0, 8'd0);     // off, park at top
        send_item(OP_STEP_DOWN, 1'b0, 8'd0, 8'd0);     // off: no change
        send_item(OP_STEP_UP, 1'b0, 8'd0, 8'd0);       // saturates at top
        send_item(OP_SET_LEVEL, 1'b1, 8'd5, 8'd0);     // one past the count
        send_item(OP_SET_LEVEL, 1'b1, 8'd255, 8'hFF);
        send_item(OP_RESTORE_LEVEL, 1'b0, 8'd3, 8'd0);
        send_item(OP_RESTORE_LEVEL, 1'b1, 8'd5, 8'd0); // range error
        send_item(OP_RESTORE_LEVEL, 1'b1, 8'd255, 8'd0);
        send_item(OP_RESTORE_PWM, 1'b1, 8'd2, 8'd80);  // exact match kept
        send_item(OP_RESTORE_PWM, 1'b1, 8'd7, 8'd100); // between entries
        send_item(OP_RESTORE_PWM, 1'b1, 8'd1, 8'd0);   // below all: off at top
        send_item(OP_RESTORE_PWM, 1'b0, 8'd255, 8'd255);
        send_item(OP_SET_ON, 1'b1, 8'd0, 8'd0);
        send_item(OP_RECONCILE, 1'b0, 8'd0, 8'd0);
        send_item(OP_NOP, 1'b1, 8'hFF, 8'hFF);
    endtask

    // shrink the count under a stored level and work from the stale level
    task automatic test_stale_level();
        load_table(5'd16, 64'h70_60_50_40_30_20_10_00, 64'hF0_E0_D0_C0_B0_A0_90_80);
        send_item(OP_SET_LEVEL, 1'b0, 8'd15, 8'd0);
        send_item(OP_STEP_UP, 1'b0, 8'd0, 8'd0);       // level 15 stays
        send_item(OP_SET_LEVEL, 1'b0, 8'd12, 8'd0);
        load_table(5'd4, 64'h70_60_50_40_30_20_10_00, 64'hF0_E0_D0_C0_B0_A0_90_80);
        send_item(OP_STEP_DOWN, 1'b0, 8'd0, 8'd0);     // 12 down to 11
        send_item(OP_RECONCILE, 1'b0, 8'd0, 8'd0);     // 11 is past the count
        send_item(OP_RESTORE_PWM, 1'b1, 8'd9, 8'hC0);
    endtask

    // count register 0 acts as one level, 31 as sixteen
    task automatic test_count_limits();
        load_table(5'd0, 64'h01_02_03_04_05_06_07_08, 64'hFE_FD_FC_FB_FA_F9_F8_F7);
        send_item(OP_STEP_UP, 1'b0, 8'd0, 8'd0);
        send_item(OP_STEP_DOWN, 1'b0, 8'd0, 8'd0);
        send_item(OP_SET_LEVEL, 1'b0, 8'd1, 8'd0);
        load_table(5'd31, 64'h01_02_03_04_05_06_07_08, 64'hFE_FD_FC_FB_FA_F9_F8_F7);
        // the spare register index must leave the table alone
        @(posedge aclk);
        write_reg(REG_UNUSED, 64'hDEAD_BEEF_0BAD_F00D);
        cfg_valid <= 1'b0;
        send_item(OP_SET_LEVEL, 1'b0, 8'd15, 8'd0);
        send_item(OP_SET_LEVEL, 1'b0, 8'd16, 8'd0);
    endtask

    // ------------------------------------------------------------------
    // Random test
    // ------------------------------------------------------------------

    // build a table: random bytes, ascending with repeats, all zero, all ones
    function automatic logic [127:0] make_table(int unsigned mode);
        logic [127:0] t;
        int           acc;
        int           i;
        acc = $urandom_range(40);
        for (i = 0; i < 16; i++) begin
            case (mode)
                0: t[i*8 +: 8] = 8'($urandom);
                1: begin
                    t[i*8 +: 8] = 8'(acc);
                    acc = acc + $urandom_range(30);
                    if (acc > 255) acc = 255;
                end
                2: t[i*8 +: 8] = 8'h00;
                default: t[i*8 +: 8] = 8'hFF;
            endcase
        end
        return t;
    endfunction

    task automatic test_random();
        int unsigned  counts[12];
        int unsigned  phase;
        int unsigned  setting;
        int unsigned  k;
        int unsigned  r;
        logic [127:0] tab;
        opcode_t      op;
        logic [7:0]   lvl;
        logic [7:0]   pwm;
        counts = '{1, 16, 0, 31, 2, 17, 0, 5, 9, 0, 3, 16};
        counts[6] = $urandom_range(1, 16);
        counts[9] = $urandom_range(31);
        for (phase = 0; phase < 4; phase++) begin
            // sweep the idling mix: none, sender, receiver, both
            case (phase)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 53; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 53; end
                default: begin src_idle_pct = 37; snk_stall_pct = 37; end
            endcase
            for (setting = 0; setting < 3; setting++) begin
                // ascending tables most of the time: searches land mid-table
                r   = $urandom_range(9);
                tab = make_table(r < 6 ? 1 : (r < 8 ? 0 : r - 6));
                load_table(5'(counts[phase*3 + setting]), tab[63:0], tab[127:64]);
                for (k = 0; k < RANDOM_ITEMS; k++) begin
                    r  = $urandom_range(99);
                    op = (r < 4) ? OP_NOP : opcode_t'(r % 7);
                    if ($urandom_range(1)) lvl = 8'($urandom_range(active_levels() + 1));
                    else lvl = 8'($urandom);
                    case ($urandom_range(3))
                        0: pwm = 8'($urandom);
                        1: pwm = table_duty(4'($urandom));
                        2: pwm = table_duty(4'($urandom)) + 8'd1;
                        default: pwm = table_duty(4'($urandom)) - 8'd1;
                    endcase
                    // favor saved triples that really match the table
                    if (op == OP_RESTORE_PWM && $urandom_range(1)) pwm = table_duty(lvl[3:0]);
                    send_item(op, 1'($urandom), lvl, pwm);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver, checker and watchdog
    // ------------------------------------------------------------------

    // stall the result channel at the configured rate
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // compare each result item with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_report = lamp_report_t'(m_tdata[13:0]);
            if (pending_reports.size() == 0) begin
                if (mismatch_count < 10)
                    $display("%0t: unexpected result on=%0d level=%0d duty=%0d status=%0d",
                             $realtime, got_report.on, got_report.level,
                             got_report.duty, got_report.status);
                mismatch_count++;
            end else begin
                want_report = pending_reports.pop_front();
                if (got_report.on !== want_report.on
                        || got_report.level !== want_report.level
                        || got_report.duty !== want_report.duty
                        || got_report.status !== want_report.status) begin
                    if (mismatch_count < 10) begin
                        $display("%0t: mismatch expected on=%0d level=%0d duty=%0d status=%0d",
                                 $realtime, want_report.on, want_report.level,
                                 want_report.duty, want_report.status);
                        $display("%0t:          got      on=%0d level=%0d duty=%0d status=%0d",
                                 $realtime, got_report.on, got_report.level,
                                 got_report.duty, got_report.status);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    // end the run when no channel moves for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $realtime, STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        // mirror the reset state of the block
        lamp_on       = 1'b0;
        lamp_level    = 4'd15;
        lamp_duty     = 8'd0;
        count_reg     = 5'd16;
        duty_table_lo = '0;
        duty_table_hi = '0;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        test_after_reset();
        test_each_opcode();
        test_stale_level();
        test_count_limits();
        test_random();

        // drain, then give any stray result time to show up
        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && pending_reports.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/dlc_pkg.sv
rtl/dlc_duty_cmp.sv
rtl/dimmer_level_controller.sv
sim/dimmer_level_controller_tb.sv
